>>> hw/rtl/tcpq_pkg.sv
package tcpq_pkg;

	// Field widths of the request and result payloads.
	localparam int AGE_W    = 7;
	localparam int HANDLE_W = 32;

	// Default number of entries in each class.
	localparam int CLASS_DEPTH_DEF = 16;

	// Request action codes.
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// Configuration register map.
	localparam int              ADDR_W         = 3;
	localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 3'h0;
	localparam logic [AGE_W-1:0]  THRESHOLD_RESET = 7'd60;

	typedef struct packed {
		logic                action;
		logic [AGE_W-1:0]    item_age;
		logic [HANDLE_W-1:0] item_handle;
	} tcpq_req_t;

	typedef struct packed {
		logic                pop_valid;
		logic [HANDLE_W-1:0] pop_handle;
		logic                pop_was_priority;
		logic                queue_empty;
		logic                push_dropped;
	} tcpq_rsp_t;

	// Occupancy status of one class ring.
	typedef struct packed {
		logic empty;
		logic full;
		logic last;
	} tcpq_ring_stat_t;

endpackage

>>> hw/rtl/tcpq_regs.sv
module tcpq_regs
	import tcpq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [AGE_W-1:0]  threshold
);

	logic [AGE_W-1:0] threshold_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == ADDR_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (wr_en) begin
			threshold_q <= pwdata[AGE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr)
			ADDR_THRESHOLD: prdata = {{(32-AGE_W){1'b0}}, threshold_q};
			default:        prdata = '0;
		endcase
	end

	assign threshold = threshold_q;

endmodule

>>> hw/rtl/tcpq_ring.sv
module tcpq_ring
	import tcpq_pkg::*;
#(
	parameter int DEPTH = CLASS_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  logic [HANDLE_W-1:0] push_data,
	input  logic                pop_en,
	output tcpq_ring_stat_t     stat,
	output logic [HANDLE_W-1:0] rd_data
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [HANDLE_W-1:0] mem_q [DEPTH];
	logic [HANDLE_W-1:0] rd_data_q;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    head_nxt;
	logic [CNT_W:0]      tail_sum;
	logic [CNT_W:0]      tail_wrap;
	logic [IDX_W-1:0]    tail_idx;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.last  = (count_q == CNT_W'(1));

	// Tail slot is head plus count, wrapped once since the sum stays below twice the depth.
	assign tail_sum  = {1'b0, count_q} + (CNT_W+1)'(head_q);
	assign tail_wrap = (tail_sum >= (CNT_W+1)'(DEPTH)) ? (tail_sum - (CNT_W+1)'(DEPTH))
	                                                   : tail_sum;
	assign tail_idx  = tail_wrap[IDX_W-1:0];
	assign head_nxt  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : (head_q + IDX_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop_en) begin
				head_q  <= head_nxt;
				count_q <= count_q - CNT_W'(1);
			end else if (push_en) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Storage holds no reset; the count keeps unwritten entries from being read.
	always_ff @(posedge clk) begin
		if (push_en) begin
			mem_q[tail_idx] <= push_data;
		end
		if (pop_en) begin
			rd_data_q <= mem_q[head_q];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/two_class_priority_queue_core.sv
// A request taken at a clock edge is registered into stage 1 and then stage 2, where its result appears with done high.
// Throughput: one request per cycle; busy stays low and each request yields exactly one result.
// The rate is set by the single registered pass: input register, ring update, result register.
// Reset (arst_n low, asynchronous) empties both classes and sets the age threshold to 60.
// The receiver cannot stall: each result is shown for one cycle only.
module two_class_priority_queue_core
	import tcpq_pkg::*;
#(
	parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  tcpq_req_t         req,
	output logic              done,
	output tcpq_rsp_t         rsp
);

	// The datapath takes a new request every cycle, so it never holds off the sender.
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Programmable age threshold from the register port.
	logic [AGE_W-1:0] threshold;

	tcpq_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	// Stage 1: the accepted request is captured. Only the valid bit needs a reset.
	logic      valid_s1;
	tcpq_req_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// Decision logic for the request in stage 1. A push picks its class by comparing the
	// age with the threshold and is dropped when that class is full. A pop drains the
	// priority class first and falls back to the normal class; on an empty queue it does
	// nothing. Each ring updates its head and count at the end of this cycle.
	tcpq_ring_stat_t prio_stat;
	tcpq_ring_stat_t norm_stat;
	logic [HANDLE_W-1:0] prio_rd;
	logic [HANDLE_W-1:0] norm_rd;
	logic is_push;
	logic is_pop;
	logic to_prio;
	logic prio_push;
	logic norm_push;
	logic prio_pop;
	logic norm_pop;
	logic dropped;
	logic prio_empty_after;
	logic norm_empty_after;

	assign is_push   = valid_s1 && (req_s1.action == ACT_PUSH);
	assign is_pop    = valid_s1 && (req_s1.action == ACT_POP);
	assign to_prio   = (req_s1.item_age >= threshold);
	assign prio_push = is_push && to_prio && !prio_stat.full;
	assign norm_push = is_push && !to_prio && !norm_stat.full;
	assign dropped   = is_push && (to_prio ? prio_stat.full : norm_stat.full);
	assign prio_pop  = is_pop && !prio_stat.empty;
	assign norm_pop  = is_pop && prio_stat.empty && !norm_stat.empty;

	// Occupancy after this request, for the empty flag of the result.
	assign prio_empty_after = (prio_stat.empty && !prio_push) || (prio_stat.last && prio_pop);
	assign norm_empty_after = (norm_stat.empty && !norm_push) || (norm_stat.last && norm_pop);

	tcpq_ring #(
		.DEPTH (CLASS_DEPTH)
	) u_prio_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (prio_push),
		.push_data (req_s1.item_handle),
		.pop_en    (prio_pop),
		.stat      (prio_stat),
		.rd_data   (prio_rd)
	);

	tcpq_ring #(
		.DEPTH (CLASS_DEPTH)
	) u_norm_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (norm_push),
		.push_data (req_s1.item_handle),
		.pop_en    (norm_pop),
		.stat      (norm_stat),
		.rd_data   (norm_rd)
	);

	// Stage 2: result flags. The popped handle comes from the ring's registered read port,
	// which is loaded at the same edge, so no extra stage is needed to line it up.
	logic valid_s2;
	logic pop_valid_s2;
	logic was_prio_s2;
	logic empty_s2;
	logic dropped_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pop_valid_s2 <= prio_pop || norm_pop;
			was_prio_s2  <= prio_pop;
			empty_s2     <= prio_empty_after && norm_empty_after;
			dropped_s2   <= dropped;
		end
	end

	// A result without a popped item reports a zero handle.
	always_comb begin
		rsp                  = '0;
		rsp.pop_valid        = pop_valid_s2;
		rsp.pop_was_priority = was_prio_s2;
		rsp.queue_empty      = empty_s2;
		rsp.push_dropped     = dropped_s2;
		if (pop_valid_s2) begin
			rsp.pop_handle = was_prio_s2 ? prio_rd : norm_rd;
		end
	end

	assign done = valid_s2;

endmodule

>>> hw/rtl/tcpq_checker.sv
module tcpq_checker
	import tcpq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input tcpq_rsp_t rsp
);

	// Every accepted request produces its result once it has passed stage 1 and stage 2.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted request produced no result");

	// No result appears without an accepted request that has passed stage 1 and stage 2.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching request");

	// A result that returned nothing carries a zero handle and no class flag.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.pop_valid) |-> (rsp.pop_handle == '0 && !rsp.pop_was_priority))
		else $error("result without item carries handle or class");

	// A dropped push means a class was full, so the queue cannot be empty and no item is popped.
	a_drop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.push_dropped) |-> (!rsp.queue_empty && !rsp.pop_valid))
		else $error("dropped push reported with empty queue or popped item");

endmodule

bind two_class_priority_queue_core tcpq_checker u_tcpq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

>>> tb/tb_two_class_priority_queue_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the two-class strict-priority queue core.
//
// Requests (push or pop) are queued by the initial block into a backlog. A
// clocked driver launches them in bursts of random length separated by random
// gaps. At the edge where a request is taken, the bench runs its own model of
// the two class rings and appends the outcome that request must produce. A
// clocked monitor compares every strobed result against the oldest outcome
// still awaited.
//
// The age threshold register is written over the APB-style port only while
// nothing is in flight, which is between phases. The phases walk the
// threshold through its reset value, both extremes and three other
// settings. The class contents are kept across phases, so a threshold change
// also lands on partly filled rings.
module tb_two_class_priority_queue_core;
	import tcpq_pkg::*;

	localparam int DEPTH = CLASS_DEPTH_DEF;
	// Longest stretch with neither a request taken nor a result seen. The
	// slowest legal case is a drain wait plus one register write, so this
	// leaves a wide margin.
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              start = 1'b0;
	logic              busy;
	tcpq_req_t         req = '0;
	logic              done;
	tcpq_rsp_t         rsp;

	two_class_priority_queue_core #(
		.CLASS_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the queue state: one ring per class with a head and a count.
	logic [HANDLE_W-1:0] prio_ring [DEPTH];
	logic [HANDLE_W-1:0] norm_ring [DEPTH];
	int                  prio_head = 0;
	int                  prio_count = 0;
	int                  norm_head = 0;
	int                  norm_count = 0;
	logic [AGE_W-1:0]    age_threshold = THRESHOLD_RESET;

	tcpq_req_t request_backlog [$];
	tcpq_rsp_t queue_outcomes [$];
	tcpq_rsp_t next_outcome;
	int        mismatch_count = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        quiet_cycles = 0;

	// Applies one request to the mirrored rings and returns the result it
	// must produce. Pushes route on age; pops favor the priority ring.
	function automatic tcpq_rsp_t apply_queue_op(input tcpq_req_t r);
		tcpq_rsp_t o;
		o = '0;
		if (r.action == ACT_PUSH) begin
			if (r.item_age >= age_threshold) begin
				if (prio_count == DEPTH) begin
					o.push_dropped = 1'b1;
				end else begin
					prio_ring[(prio_head + prio_count) % DEPTH] = r.item_handle;
					prio_count++;
				end
			end else begin
				if (norm_count == DEPTH) begin
					o.push_dropped = 1'b1;
				end else begin
					norm_ring[(norm_head + norm_count) % DEPTH] = r.item_handle;
					norm_count++;
				end
			end
		end else if (prio_count != 0) begin
			o.pop_valid = 1'b1;
			o.pop_handle = prio_ring[prio_head];
			o.pop_was_priority = 1'b1;
			prio_head = (prio_head + 1) % DEPTH;
			prio_count--;
		end else if (norm_count != 0) begin
			o.pop_valid = 1'b1;
			o.pop_handle = norm_ring[norm_head];
			norm_head = (norm_head + 1) % DEPTH;
			norm_count--;
		end
		o.queue_empty = (prio_count == 0 && norm_count == 0);
		return o;
	endfunction

	// Handles lean toward all zeros and all ones now and then.
	function automatic logic [HANDLE_W-1:0] pick_handle();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return $urandom;
	endfunction

	// Picks an age in the chosen class under the current threshold; a zero
	// threshold gives a priority age. The boundary and far extreme are favored.
	function automatic logic [AGE_W-1:0] pick_age(input bit to_prio);
		int lo;
		int hi;
		int sel;
		if (to_prio || age_threshold == 0) begin
			lo = age_threshold;
			hi = 127;
		end else begin
			lo = 0;
			hi = age_threshold - 1;
		end
		sel = $urandom_range(0, 3);
		if (sel == 0)
			return (to_prio || age_threshold == 0) ? lo : hi;
		if (sel == 1)
			return (to_prio || age_threshold == 0) ? hi : lo;
		return $urandom_range(lo, hi);
	endfunction

	function automatic tcpq_req_t make_request(input logic act, input logic [AGE_W-1:0] age,
			input logic [HANDLE_W-1:0] handle);
		tcpq_req_t r;
		r.action = act;
		r.item_age = age;
		r.item_handle = handle;
		return r;
	endfunction

	// A pop carries random age and handle bits, which the block must ignore.
	function automatic tcpq_req_t random_pop();
		return make_request(ACT_POP, $urandom_range(0, 127), $urandom);
	endfunction

	// Appends roughly the given number of random requests. The mix is built
	// from runs: interleaved traffic, runs into one class that can fill it
	// past full so that pushes get dropped, runs of pops that can drain into
	// empty pops, and runs of pushes spread over both classes.
	task automatic queue_random_items(input int total);
		int made;
		int kind;
		int n;
		int i;
		bit side;
		made = 0;
		while (made < total) begin
			kind = $urandom_range(0, 3);
			side = $urandom_range(0, 1);
			case (kind)
				0: begin
					n = $urandom_range(4, 24);
					for (i = 0; i < n; i++) begin
						if ($urandom_range(0, 1) == 0)
							request_backlog.push_back(make_request(ACT_PUSH,
								pick_age($urandom_range(0, 1)), pick_handle()));
						else
							request_backlog.push_back(random_pop());
					end
				end
				1: begin
					n = $urandom_range(12, 20);
					for (i = 0; i < n; i++)
						request_backlog.push_back(make_request(ACT_PUSH, pick_age(side),
							pick_handle()));
				end
				2: begin
					n = $urandom_range(8, 36);
					for (i = 0; i < n; i++)
						request_backlog.push_back(random_pop());
				end
				default: begin
					n = $urandom_range(4, 16);
					for (i = 0; i < n; i++)
						request_backlog.push_back(make_request(ACT_PUSH,
							pick_age($urandom_range(0, 1)), pick_handle()));
				end
			endcase
			made += n;
		end
	endtask

	// Returns once the backlog is empty, no request is being offered and every
	// awaited result has come back. Sampling on the falling edge avoids racing
	// the driver.
	task automatic wait_until_idle();
		do
			@(negedge clk);
		while (request_backlog.size() != 0 || start || queue_outcomes.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// One APB write of the threshold: setup cycle, then access until pready.
	task automatic write_threshold(input logic [AGE_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_THRESHOLD;
		pwdata <= {{(32 - AGE_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		age_threshold = value;
	endtask

	// Driver: launches requests from the backlog in bursts. A request is
	// taken at an edge where start is high and busy is low; the model runs
	// right there so the outcome queue stays in request order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				queue_outcomes.push_back(apply_queue_op(req));
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					// Now and then a long burst with no gaps at all.
					if (burst_left == 0)
						burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
							: $urandom_range(1, 12);
					req <= request_backlog.pop_front();
					start <= 1'b1;
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(input string name, input logic [HANDLE_W-1:0] want,
			input logic [HANDLE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Monitor: every strobed result must match the oldest awaited outcome.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (queue_outcomes.size() == 0) begin
				$error("result with no request outstanding: %h", rsp);
				mismatch_count++;
			end else begin
				next_outcome = queue_outcomes.pop_front();
				compare_field("pop_valid", next_outcome.pop_valid, rsp.pop_valid);
				compare_field("pop_handle", next_outcome.pop_handle, rsp.pop_handle);
				compare_field("pop_was_priority", next_outcome.pop_was_priority,
					rsp.pop_was_priority);
				compare_field("queue_empty", next_outcome.queue_empty, rsp.queue_empty);
				compare_field("push_dropped", next_outcome.push_dropped, rsp.push_dropped);
			end
		end
	end

	// Watchdog: a hung block stops taking requests and returning results.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [AGE_W-1:0] plan [5];
		int p;
		plan[0] = 7'd0;
		plan[1] = 7'd127;
		plan[2] = 7'd1;
		plan[3] = $urandom_range(2, 125);
		plan[4] = 7'd126;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening under the reset threshold of 60: a pop on the empty
		// queue, pushes at both sides of the threshold with extreme ages and
		// handles, then pops that must take the priority items first and end
		// on an empty queue, and one more pop with nothing left.
		request_backlog.push_back(make_request(ACT_POP, 7'd127, '1));
		request_backlog.push_back(make_request(ACT_PUSH, 7'd0, '0));
		request_backlog.push_back(make_request(ACT_PUSH, 7'd59, 32'h5A5A_5A5A));
		request_backlog.push_back(make_request(ACT_PUSH, 7'd60, '1));
		request_backlog.push_back(make_request(ACT_PUSH, 7'd127, 32'hA5A5_A5A5));
		repeat (4) request_backlog.push_back(random_pop());
		request_backlog.push_back(make_request(ACT_POP, 7'd0, '0));
		wait_until_idle();

		// Random traffic under the reset threshold, then under each new one.
		queue_random_items(PHASE_ITEMS);
		wait_until_idle();
		for (p = 0; p < 5; p++) begin
			write_threshold(plan[p]);
			queue_random_items(PHASE_ITEMS);
			wait_until_idle();
		end

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
